// File: rtl/core/phl_pkg.sv
// phl_pkg: shared types and constants of the packet header locator
// request and result payload structs, link type codes, ethertype and protocol values
// no dependencies
`timescale 1ns / 1ps

package phl_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } phl_req_t;

  typedef struct packed {
    logic        network_found;
    logic        network_is_ipv6;
    logic [4:0]  network_offset;
    logic        fragment_flag;
    logic        transport_found;
    logic [7:0]  transport_proto;
    logic [6:0]  transport_offset;
    logic        payload_found;
    logic [6:0]  payload_offset;
    logic [15:0] udp_length;
  } phl_res_t;

  // result handoff from the parser to the output stage
  typedef struct packed {
    logic     valid;
    phl_res_t data;
  } phl_push_t;

  localparam logic [1:0] LINK_ETH    = 2'd0;
  localparam logic [1:0] LINK_COOKED = 2'd1;

  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_TYPE_IPV6 = 16'h86DD;
  localparam logic [15:0] ETH_TYPE_VLAN = 16'h8100;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;

  localparam logic [4:0] NOFF_ETH      = 5'd14;
  localparam logic [4:0] NOFF_ETH_VLAN = 5'd18;
  localparam logic [4:0] NOFF_COOKED   = 5'd16;

endpackage

// File: rtl/core/phl_frame_parser.sv
// phl_frame_parser: per-byte header field capture and end-of-frame summary
// frame state registers plus the combinational summary handed to the output stage
// depends on phl_pkg
`timescale 1ns / 1ps

module phl_frame_parser
  import phl_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  phl_req_t   req,
  input  logic [1:0] link_type,
  output phl_push_t  push
);

  localparam int LW = COUNT_BITS + 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] byte_count, byte_count_next;
  logic [15:0]           frame_etype, frame_etype_next;
  logic                  vlan_seen, vlan_seen_next;
  logic [7:0]            ip_version_hdrlen, ip_version_hdrlen_next;
  logic [15:0]           ip_flags_offset, ip_flags_offset_next;
  logic [7:0]            ip_protocol, ip_protocol_next;
  logic [15:0]           udp_len_field, udp_len_field_next;

  logic [COUNT_BITS-1:0] pos;
  logic [LW-1:0]         len;
  logic [7:0]            b;
  logic [4:0]            noff;
  logic [6:0]            tpos;
  logic                  link_ok;
  logic [15:0]           et;
  logic                  found;
  logic [5:0]            hl;
  logic [6:0]            toff;
  logic [6:0]            poff;
  phl_res_t              res;

  always_comb begin
    pos                    = byte_count;
    b                      = req.data_byte;
    frame_etype_next       = frame_etype;
    vlan_seen_next         = vlan_seen;
    ip_version_hdrlen_next = ip_version_hdrlen;
    ip_flags_offset_next   = ip_flags_offset;
    ip_protocol_next       = ip_protocol;
    udp_len_field_next     = udp_len_field;
    noff                   = NOFF_ETH;
    link_ok                = 1'b0;

    // link header
    case (link_type)
      LINK_ETH: begin
        link_ok = 1'b1;
        if (pos == COUNT_BITS'(12)) frame_etype_next[15:8] = b;
        if (pos == COUNT_BITS'(13)) begin
          frame_etype_next[7:0] = b;
          if (frame_etype_next == ETH_TYPE_VLAN) vlan_seen_next = 1'b1;
        end
        if (vlan_seen_next && pos == COUNT_BITS'(16)) frame_etype_next[15:8] = b;
        if (vlan_seen_next && pos == COUNT_BITS'(17)) frame_etype_next[7:0] = b;
        noff = vlan_seen_next ? NOFF_ETH_VLAN : NOFF_ETH;
      end
      LINK_COOKED: begin
        link_ok = 1'b1;
        if (pos == COUNT_BITS'(14)) frame_etype_next[15:8] = b;
        if (pos == COUNT_BITS'(15)) frame_etype_next[7:0] = b;
        noff = NOFF_COOKED;
      end
      default: begin
        link_ok = 1'b0;
      end
    endcase

    // network and transport fields; udp length position uses the stored ihl
    tpos = {2'b00, noff} + {1'b0, ip_version_hdrlen[3:0], 2'b00};
    if (link_ok && pos >= COUNT_BITS'(noff)) begin
      if (pos == COUNT_BITS'(noff)) ip_version_hdrlen_next = b;
      if (pos == COUNT_BITS'({2'b00, noff} + 7'd6)) ip_flags_offset_next[15:8] = b;
      if (pos == COUNT_BITS'({2'b00, noff} + 7'd7)) ip_flags_offset_next[7:0] = b;
      if (pos == COUNT_BITS'({2'b00, noff} + 7'd9)) ip_protocol_next = b;
      if (pos == COUNT_BITS'(tpos + 7'd4)) udp_len_field_next[15:8] = b;
      if (pos == COUNT_BITS'(tpos + 7'd5)) udp_len_field_next[7:0] = b;
    end

    byte_count_next = (byte_count == COUNT_MAX) ? byte_count : byte_count + 1'b1;

    // summary, meaningful on the last byte
    len   = {1'b0, pos} + LW'(1);
    et    = 16'h0000;
    found = 1'b0;
    if (link_type == LINK_ETH && len >= LW'(14)) begin
      et    = (vlan_seen_next && len < LW'(18)) ? ETH_TYPE_VLAN : frame_etype_next;
      found = 1'b1;
    end else if (link_type == LINK_COOKED && len >= LW'(16)) begin
      et    = frame_etype_next;
      found = 1'b1;
    end
    if (et != ETH_TYPE_IPV4 && et != ETH_TYPE_IPV6) found = 1'b0;

    hl   = {ip_version_hdrlen_next[3:0], 2'b00};
    toff = {2'b00, noff} + {1'b0, hl};
    poff = toff + 7'd8;

    res = '0;
    if (found) begin
      res.network_found   = 1'b1;
      res.network_offset  = noff;
      res.network_is_ipv6 = (et == ETH_TYPE_IPV6);
      if (et != ETH_TYPE_IPV6) begin
        res.fragment_flag = |ip_flags_offset_next[13:0];
        if (len >= LW'({2'b00, noff} + 7'd20) && ip_version_hdrlen_next[7:4] == 4'd4 &&
            len >= LW'(toff)) begin
          res.transport_found  = 1'b1;
          res.transport_proto  = ip_protocol_next;
          res.transport_offset = toff;
          if (ip_protocol_next == PROTO_UDP && len >= LW'(poff)) begin
            res.payload_found  = 1'b1;
            res.payload_offset = poff;
            res.udp_length     = udp_len_field_next;
          end
        end
      end
    end

    push.valid = accept && req.last_byte;
    push.data  = res;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && req.last_byte)) begin
      byte_count        <= '0;
      frame_etype       <= '0;
      vlan_seen         <= 1'b0;
      ip_version_hdrlen <= '0;
      ip_flags_offset   <= '0;
      ip_protocol       <= '0;
      udp_len_field     <= '0;
    end else if (accept) begin
      byte_count        <= byte_count_next;
      frame_etype       <= frame_etype_next;
      vlan_seen         <= vlan_seen_next;
      ip_version_hdrlen <= ip_version_hdrlen_next;
      ip_flags_offset   <= ip_flags_offset_next;
      ip_protocol       <= ip_protocol_next;
      udp_len_field     <= udp_len_field_next;
    end
  end

  // frame state is cleared after the last byte
  assert property (@(posedge clk) disable iff (rst)
    accept && req.last_byte |=> byte_count == '0 && frame_etype == '0 && !vlan_seen)
    else $error("frame state not cleared after last byte");

  // counter only moves on accepted bytes
  assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(byte_count))
    else $error("byte count moved without a request");

  // count holds at its maximum on long frames
  assert property (@(posedge clk) disable iff (rst)
    accept && !req.last_byte && byte_count == COUNT_MAX |=> byte_count == COUNT_MAX)
    else $error("byte count wrapped");

endmodule

// File: rtl/core/phl_result_skid.sv
// phl_result_skid: output register with one skid slot for summary results
// keeps the input side free of any combinational path from the output stall
// depends on phl_pkg
`timescale 1ns / 1ps

module phl_result_skid
  import phl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  phl_push_t push,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output phl_res_t  out_data
);

  logic     skid_valid;
  phl_res_t skid_data;
  logic     pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= push.valid;
      end
    end else if (push.valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_data <= skid_valid ? skid_data : push.data;
    end else if (push.valid) begin
      skid_data <= push.data;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot holds a result ahead of the output register");

  assert property (@(posedge clk) disable iff (rst)
    !(push.valid && skid_valid))
    else $error("result pushed while both slots are full");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall && push.valid |=> skid_valid && out_valid)
    else $error("result dropped while output stalled");

endmodule

// File: rtl/core/packet_header_locator.sv
// packet_header_locator: one byte per cycle unless stalled, registered summary per frame
// throughput: one request per cycle, held off only while both result slots are full
// result register, or skid slot if stalled, loads at the edge that accepts the last byte
// reset: synchronous, clears link type to ethernet, frame state and result slots
// depends on phl_pkg, phl_frame_parser, phl_result_skid
`timescale 1ns / 1ps

module packet_header_locator
  import phl_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic [1:0] cfg_write_data,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  phl_req_t   byte_data,
  output logic       result_valid,
  input  logic       result_stall,
  output phl_res_t   result_data
);

  logic      [1:0] link_type;
  logic            accept;
  logic            full;
  phl_push_t       push;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_type <= LINK_ETH;
    end else if (cfg_write_en) begin
      link_type <= cfg_write_data;
    end
  end

  assign byte_stall = full;
  assign accept     = byte_valid && !byte_stall;

  phl_frame_parser #(
    .COUNT_BITS(COUNT_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req       (byte_data),
    .link_type (link_type),
    .push      (push)
  );

  phl_result_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_data  (result_data)
  );

endmodule
